// ----- rtl/state_space_force_estimator_defines.svh -----
// Assertion macros shared by the state-space force estimator RTL.
`ifndef STATE_SPACE_FORCE_ESTIMATOR_DEFINES_SVH
`define STATE_SPACE_FORCE_ESTIMATOR_DEFINES_SVH

`ifndef SYNTHESIS

// Implication in the same cycle, checked at every rising clock edge out of reset.
`define SSFE_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ssfe assertion failed");

// Implication checked in the cycle after the antecedent.
`define SSFE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ssfe assertion failed");

`else

`define SSFE_ASSERT_IMP(label, clk, rst, ante, cons)
`define SSFE_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/ssfe_pkg.sv -----
// Constants, coefficient tables and pipeline types of the state-space force estimator.
`timescale 1ns / 1ps

package ssfe_pkg;

   localparam int ORDER      = 6;
   localparam int NUM_OUT    = 2;
   localparam int NUM_IN     = 2;
   localparam int COEF_W     = 18;
   localparam int FRAC_SHIFT = 12;
   localparam int IDX_W      = $clog2(ORDER);
   localparam int TERM_W     = $clog2(ORDER + NUM_IN);
   localparam int OUT_W      = $clog2(NUM_OUT);
   localparam int IN_W       = $clog2(NUM_IN);

   typedef logic signed [COEF_W-1:0] coef_type;

   // Q6.12 model matrices.
   localparam coef_type MAT_A [ORDER][ORDER] = '{
      '{ 18'sd3128,   18'sd146,  -18'sd172,  -18'sd628,   18'sd111,   18'sd986},
      '{  18'sd390,  18'sd3051,  18'sd1195,   18'sd304,   -18'sd62,  -18'sd379},
      '{ -18'sd502, -18'sd1758,  18'sd3684,   18'sd248,   -18'sd50,  -18'sd363},
      '{  18'sd433,  -18'sd547,  -18'sd582,  18'sd2491,   18'sd596,  -18'sd419},
      '{ 18'sd1572, -18'sd2090, -18'sd1585, -18'sd3958,  18'sd5580, -18'sd1588},
      '{ -18'sd367,   18'sd887,   18'sd291, -18'sd1153,   18'sd396,  18'sd4536}
   };

   localparam coef_type MAT_B [ORDER][NUM_IN] = '{
      '{  -18'sd274,   -18'sd32},
      '{ -18'sd1030,  -18'sd242},
      '{  -18'sd972,   18'sd768},
      '{ -18'sd1495,  18'sd2735},
      '{  18'sd3955,  18'sd1903},
      '{  18'sd7511, -18'sd3614}
   };

   localparam coef_type MAT_C [NUM_OUT][ORDER] = '{
      '{  18'sd2925,  -18'sd809, 18'sd8707,    -18'sd529,   18'sd177,   18'sd57},
      '{ -18'sd2068, -18'sd9503,  18'sd675, -18'sd105876, 18'sd33825, 18'sd9107}
   };

   // Control that travels with each multiply-accumulate term down the pipeline.
   typedef struct packed {
      logic             vld;
      logic             first;
      logic             last;
      logic             is_c;
      logic             use_in;
      logic             in_sel;
      logic             zero;
      logic [IDX_W-1:0] row;
   } pipe_ctrl_type;

   // Coefficient of one term: A or B columns while updating, C while forming outputs.
   function automatic coef_type coef_at(input logic is_c, input logic [IDX_W-1:0] row,
                                        input logic [TERM_W-1:0] term);
      logic [TERM_W-1:0] b_term;
      coef_type          res;
      b_term = term - TERM_W'(ORDER);
      if (is_c) begin
         res = MAT_C[row[OUT_W-1:0]][term[IDX_W-1:0]];
      end else if (term < TERM_W'(ORDER)) begin
         res = MAT_A[row][term[IDX_W-1:0]];
      end else begin
         res = MAT_B[row][b_term[IN_W-1:0]];
      end
      return res;
   endfunction

endpackage

// ----- rtl/state_space_force_estimator.sv -----
// Sixth-order state-space force estimator built around one shared multiply-accumulate unit.
`timescale 1ns / 1ps
`include "state_space_force_estimator_defines.svh"

// Usage:
// Each input word on the req_ channel carries one sample: motor effort and position, both
// signed Q8.8. The block advances its six-entry state as x = A*x + B*u and then returns
// y = C*x on the rsp_ channel as two saturated Q16.16 values, the second being the force
// estimate. One result word is produced for every input word.
// The state lives in a two-bank memory; one bank holds the old state while the other
// receives the new one, and the banks swap at the end of each sample.
// All terms go through a single multiplier in a four-stage read, multiply, accumulate and
// round pipeline. A sample takes 48 terms for the update and 12 for the outputs; the
// pipeline drains after each part, and then the result word is loaded into the output
// register. A new sample is accepted once the previous one has left the pipeline. The
// finished result sits in an output register, so the next sample can be accepted while it
// waits; if the receiver still holds off when the following result is done, the block
// waits with that result and accepts nothing.
// Reset clears the state to zero (tracked by a flag, not by clearing the memory) and
// empties the pipeline and the output register.
module state_space_force_estimator
   import ssfe_pkg::*;
#(
   parameter int STATE_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] effort, [31:16] position
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata    // [31:0] first_output, [63:32] force_estimate
);

   localparam int PROD_W    = STATE_WIDTH + COEF_W;
   localparam int ACC_W     = STATE_WIDTH + 20;
   localparam int RND_W     = ACC_W - FRAC_SHIFT;
   localparam int ADDR_W    = IDX_W + 1;
   localparam int MEM_DEPTH = 2 ** ADDR_W;

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_UPD      = 3'd1;
   localparam logic [2:0] ST_UPD_WAIT = 3'd2;
   localparam logic [2:0] ST_OUT      = 3'd3;
   localparam logic [2:0] ST_OUT_WAIT = 3'd4;
   localparam logic [2:0] ST_DONE     = 3'd5;

   localparam logic [TERM_W-1:0] LAST_A_TERM = TERM_W'(ORDER + NUM_IN - 1);
   localparam logic [TERM_W-1:0] LAST_C_TERM = TERM_W'(ORDER - 1);
   localparam logic [TERM_W-1:0] POS_TERM    = TERM_W'(ORDER + 1);
   localparam logic [IDX_W-1:0]  LAST_A_ROW  = IDX_W'(ORDER - 1);
   localparam logic [IDX_W-1:0]  LAST_C_ROW  = IDX_W'(NUM_OUT - 1);

   logic [2:0]              state_ff, state_in;
   logic [IDX_W-1:0]        row_ff, row_in;
   logic [TERM_W-1:0]       term_ff, term_in;
   logic                    bank_ff, bank_in;
   logic                    primed_ff, primed_in;
   logic                    rsp_vld_ff, rsp_vld_in;
   logic [63:0]             rsp_data_ff;
   logic signed [15:0]      eff_ff, pos_ff;

   pipe_ctrl_type           iss;
   pipe_ctrl_type           s1_ff, s2_ff, s3_ff, s4_ff, s3_in;
   logic [ADDR_W-1:0]       rd_addr;
   logic signed [STATE_WIDTH-1:0] state_mem [MEM_DEPTH];
   logic signed [STATE_WIDTH-1:0] rd_data_ff;
   coef_type                coef_ff;
   logic signed [STATE_WIDTH-1:0] opnd;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [ACC_W-1:0] rnd_sum;
   logic signed [RND_W-1:0] rnd_ff, rnd_in;
   logic signed [STATE_WIDTH-1:0] state_sat;
   logic [31:0]             out_sat;
   logic [31:0]             y_ff [NUM_OUT];
   logic                    pipe_empty;
   logic                    req_accept;
   logic                    rsp_load;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign pipe_empty = !(s1_ff.vld || s2_ff.vld || s3_ff.vld || s4_ff.vld);

   // Sequencer: walks rows and terms, one read and multiply per cycle in ST_UPD and ST_OUT.
   always_comb begin
      state_in  = state_ff;
      row_in    = row_ff;
      term_in   = term_ff;
      bank_in   = bank_ff;
      primed_in = primed_ff;
      rsp_load  = 1'b0;
      iss       = '0;
      rd_addr   = {bank_ff, term_ff[IDX_W-1:0]};
      unique case (state_ff)
         ST_IDLE: begin
            row_in  = '0;
            term_in = '0;
            if (req_tvalid) begin
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            iss.vld    = 1'b1;
            iss.first  = (term_ff == '0);
            iss.last   = (term_ff == LAST_A_TERM);
            iss.use_in = (term_ff >= TERM_W'(ORDER));
            iss.in_sel = (term_ff == POS_TERM);
            iss.zero   = !primed_ff;
            iss.row    = row_ff;
            rd_addr    = {bank_ff, term_ff[IDX_W-1:0]};
            if (iss.last) begin
               term_in = '0;
               if (row_ff == LAST_A_ROW) begin
                  row_in   = '0;
                  state_in = ST_UPD_WAIT;
               end else begin
                  row_in = row_ff + 1'b1;
               end
            end else begin
               term_in = term_ff + 1'b1;
            end
         end
         ST_UPD_WAIT: begin
            // The outputs read the new state, so the last update write must land first.
            if (pipe_empty) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            iss.vld   = 1'b1;
            iss.first = (term_ff == '0);
            iss.last  = (term_ff == LAST_C_TERM);
            iss.is_c  = 1'b1;
            iss.row   = row_ff;
            rd_addr   = {!bank_ff, term_ff[IDX_W-1:0]};
            if (iss.last) begin
               term_in = '0;
               if (row_ff == LAST_C_ROW) begin
                  row_in   = '0;
                  state_in = ST_OUT_WAIT;
               end else begin
                  row_in = row_ff + 1'b1;
               end
            end else begin
               term_in = term_ff + 1'b1;
            end
         end
         ST_OUT_WAIT: begin
            if (pipe_empty) begin
               bank_in   = !bank_ff;
               primed_in = 1'b1;
               state_in  = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_vld_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      if (rsp_load) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
   end

   // Multiply stage: operand is a state entry (zero until primed) or an input scaled to Q.16.
   always_comb begin
      if (s1_ff.use_in) begin
         opnd = (s1_ff.in_sel ? STATE_WIDTH'(pos_ff) : STATE_WIDTH'(eff_ff)) <<< 8;
      end else if (s1_ff.zero) begin
         opnd = '0;
      end else begin
         opnd = rd_data_ff;
      end
      prod_in = PROD_W'(coef_ff) * PROD_W'(opnd);
   end

   always_comb begin
      acc_in = s2_ff.first ? ACC_W'(prod_ff) : acc_ff + ACC_W'(prod_ff);
      s3_in     = s2_ff;
      s3_in.vld = s2_ff.vld && s2_ff.last;
   end

   // Round half up from Q.28 to Q.16.
   always_comb begin
      rnd_sum = acc_ff + ACC_W'(2 ** (FRAC_SHIFT - 1));
      rnd_in  = rnd_sum[ACC_W-1:FRAC_SHIFT];
   end

   // Saturation: the value fits when all bits above the target sign bit match it.
   always_comb begin
      if ((&rnd_ff[RND_W-1:STATE_WIDTH-1]) || !(|rnd_ff[RND_W-1:STATE_WIDTH-1])) begin
         state_sat = rnd_ff[STATE_WIDTH-1:0];
      end else begin
         state_sat = {rnd_ff[RND_W-1], {(STATE_WIDTH - 1){!rnd_ff[RND_W-1]}}};
      end
      if ((&rnd_ff[RND_W-1:31]) || !(|rnd_ff[RND_W-1:31])) begin
         out_sat = rnd_ff[31:0];
      end else begin
         out_sat = {rnd_ff[RND_W-1], {31{!rnd_ff[RND_W-1]}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         row_ff     <= '0;
         term_ff    <= '0;
         bank_ff    <= 1'b0;
         primed_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         s1_ff      <= '0;
         s2_ff      <= '0;
         s3_ff      <= '0;
         s4_ff      <= '0;
      end else begin
         state_ff   <= state_in;
         row_ff     <= row_in;
         term_ff    <= term_in;
         bank_ff    <= bank_in;
         primed_ff  <= primed_in;
         rsp_vld_ff <= rsp_vld_in;
         s1_ff      <= iss;
         s2_ff      <= s1_ff;
         s3_ff      <= s3_in;
         s4_ff      <= s3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         eff_ff <= req_tdata[15:0];
         pos_ff <= req_tdata[31:16];
      end
      coef_ff <= coef_at(iss.is_c, iss.row, term_ff);
      prod_ff <= prod_in;
      if (s2_ff.vld) begin
         acc_ff <= acc_in;
      end
      rnd_ff <= rnd_in;
      if (s4_ff.vld && s4_ff.is_c) begin
         y_ff[s4_ff.row[OUT_W-1:0]] <= out_sat;
      end
      if (rsp_load) begin
         rsp_data_ff <= {y_ff[1], y_ff[0]};
      end
   end

   // State memory: the update reads the old state in one bank and writes the new to the other.
   always_ff @(posedge clock) begin
      if (s4_ff.vld && !s4_ff.is_c) begin
         state_mem[{!bank_ff, s4_ff.row}] <= state_sat;
      end
      rd_data_ff <= state_mem[rd_addr];
   end

   `SSFE_ASSERT_IMP(a_upd_write_phase, clock, reset, s4_ff.vld && !s4_ff.is_c,
                    state_ff == ST_UPD || state_ff == ST_UPD_WAIT)
   `SSFE_ASSERT_IMP(a_out_after_writes, clock, reset, state_ff == ST_OUT,
                    !(s1_ff.vld && !s1_ff.is_c) && !(s2_ff.vld && !s2_ff.is_c) &&
                    !(s3_ff.vld && !s3_ff.is_c) && !(s4_ff.vld && !s4_ff.is_c))
   `SSFE_ASSERT_NEXT(a_bank_swap, clock, reset, state_ff == ST_OUT_WAIT && pipe_empty,
                     bank_ff != $past(bank_ff) && primed_ff)
   `SSFE_ASSERT_NEXT(a_result_load, clock, reset, rsp_load,
                     rsp_vld_ff && state_ff == ST_IDLE)

endmodule
